// File: src/i2cmbe_pkg.sv
// shared types and constants of the i2c master bit engine
`default_nettype none

package i2cmbe_pkg;

   localparam int unsigned TickWidth  = 16;
   localparam int unsigned PhaseWidth = 5;
   localparam int unsigned QueueDepth = 2;

   typedef enum logic [2:0] {
      MODE_START  = 3'd0,
      MODE_WRITE  = 3'd1,
      MODE_RX_ACK = 3'd2,
      MODE_READ   = 3'd3,
      MODE_TX_ACK = 3'd4,
      MODE_STOP   = 3'd5
   } mode_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] mode;
      logic [7:0] data_byte;
      logic       ack_bit;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_seen;
   } rsp_type;

   // one classified tick as queued between front and back
   typedef struct packed {
      logic       start;
      mode_type   mode;
      logic [7:0] tx_byte;
      logic       sda_in;
   } tick_type;

endpackage

`default_nettype wire

// File: src/i2cmbe_front.sv
// front end: accepts tick words and classifies the offered command
`default_nettype none

module i2cmbe_front (
   input  wire                    req_valid,
   output logic                   req_ready,
   input  i2cmbe_pkg::req_type    req_data,
   output logic                   push_valid,
   input  wire                    push_ready,
   output i2cmbe_pkg::tick_type   push_data
);

   logic mode_ok;

   always_comb begin
      unique case (req_data.mode)
         i2cmbe_pkg::MODE_START,
         i2cmbe_pkg::MODE_WRITE,
         i2cmbe_pkg::MODE_RX_ACK,
         i2cmbe_pkg::MODE_READ,
         i2cmbe_pkg::MODE_TX_ACK,
         i2cmbe_pkg::MODE_STOP: mode_ok = 1'b1;
         default:               mode_ok = 1'b0;
      endcase
   end

   always_comb begin
      push_data.start   = req_data.cmd_valid & mode_ok;
      push_data.mode    = i2cmbe_pkg::mode_type'(req_data.mode);
      push_data.sda_in  = req_data.sda_in;
      // send ack carries its level in bit 0
      if (req_data.mode == i2cmbe_pkg::MODE_TX_ACK) begin
         push_data.tx_byte = {7'd0, req_data.ack_bit};
      end else begin
         push_data.tx_byte = req_data.data_byte;
      end
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

`default_nettype wire

// File: src/i2cmbe_queue.sv
// two-entry queue between front and back
`default_nettype none

module i2cmbe_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push_valid,
   output logic                   push_ready,
   input  i2cmbe_pkg::tick_type   push_data,
   output logic                   pop_valid,
   input  wire                    pop_ready,
   output i2cmbe_pkg::tick_type   pop_data
);

   localparam int unsigned PtrWidth = $clog2(i2cmbe_pkg::QueueDepth);

   i2cmbe_pkg::tick_type entry_ff [i2cmbe_pkg::QueueDepth];
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]    count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != (PtrWidth+1)'(i2cmbe_pkg::QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (PtrWidth+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PtrWidth+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: src/i2cmbe_back.sv
// back end: phase sequencer, sda sampling and result register
`default_nettype none

module i2cmbe_back (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire  [i2cmbe_pkg::TickWidth-1:0]         ticks_per_phase,
   input  wire                                      pop_valid,
   output logic                                     pop_ready,
   input  i2cmbe_pkg::tick_type                     pop_data,
   output logic                                     rsp_valid,
   input  wire                                      rsp_ready,
   output i2cmbe_pkg::rsp_type                      rsp_data
);

   localparam int unsigned TW = i2cmbe_pkg::TickWidth;
   localparam int unsigned PW = i2cmbe_pkg::PhaseWidth;

   i2cmbe_pkg::mode_type mode_ff, mode_in;
   logic                 busy_ff, busy_in;
   logic [PW-1:0]        phase_ff, phase_in;
   logic [TW-1:0]        tick_ff, tick_in;
   logic [7:0]           shift_ff, shift_in;
   logic                 ack_ff, ack_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic [7:0]           tx_ff, tx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   i2cmbe_pkg::rsp_type  rsp_ff, rsp_in;

   logic                 pop;
   logic                 done;
   logic [TW-1:0]        limit;
   logic [TW-1:0]        tick_inc;
   logic [PW-1:0]        phase_inc;
   logic [1:0]           pins;

   function automatic logic [PW-1:0] phase_count(input i2cmbe_pkg::mode_type m);
      logic [PW-1:0] n;
      begin
         unique case (m)
            i2cmbe_pkg::MODE_START:  n = PW'(4);
            i2cmbe_pkg::MODE_WRITE:  n = PW'(24);
            i2cmbe_pkg::MODE_RX_ACK: n = PW'(3);
            i2cmbe_pkg::MODE_READ:   n = PW'(17);
            i2cmbe_pkg::MODE_TX_ACK: n = PW'(3);
            default:                 n = PW'(3);
         endcase
         return n;
      end
   endfunction

   // pin levels {scl, sda} once phase p is applied
   function automatic logic [1:0] apply_phase(input i2cmbe_pkg::mode_type m,
                                              input logic [PW-1:0] p,
                                              input logic [7:0] tx,
                                              input logic scl, input logic sda);
      logic [8:0]    prod;
      logic [PW-1:0] third;
      logic [PW-1:0] rem;
      logic [2:0]    bit_sel;
      logic          s, d;
      begin
         s       = scl;
         d       = sda;
         // p / 3 by reciprocal, exact for five-bit p
         prod    = {4'd0, p} * 9'd11;
         third   = {1'b0, prod[8:5]};
         rem     = p - (third + {third[PW-2:0], 1'b0});
         bit_sel = third[2:0];
         unique case (m)
            i2cmbe_pkg::MODE_START: begin
               if (p == PW'(0)) d = 1'b1;
               else if (p == PW'(1)) s = 1'b1;
               else if (p == PW'(2)) d = 1'b0;
               else s = 1'b0;
            end
            i2cmbe_pkg::MODE_WRITE: begin
               if (rem == PW'(0)) d = tx[3'd7 - bit_sel];
               else if (rem == PW'(1)) s = 1'b1;
               else s = 1'b0;
            end
            i2cmbe_pkg::MODE_READ: begin
               if (p == PW'(0)) d = 1'b1;
               else s = p[0];
            end
            i2cmbe_pkg::MODE_RX_ACK, i2cmbe_pkg::MODE_TX_ACK: begin
               if (p == PW'(0)) d = (m == i2cmbe_pkg::MODE_RX_ACK) ? 1'b1 : tx[0];
               else if (p == PW'(1)) s = 1'b1;
               else s = 1'b0;
            end
            default: begin
               if (p == PW'(0)) d = 1'b0;
               else if (p == PW'(1)) s = 1'b1;
               else d = 1'b1;
            end
         endcase
         return {s, d};
      end
   endfunction

   assign pop       = pop_valid & (~rsp_valid_ff | rsp_ready);
   assign pop_ready = ~rsp_valid_ff | rsp_ready;
   assign limit     = (ticks_per_phase == '0) ? TW'(1) : ticks_per_phase;
   assign tick_inc  = tick_ff + TW'(1);
   assign phase_inc = phase_ff + PW'(1);

   always_comb begin
      mode_in  = mode_ff;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      shift_in = shift_ff;
      ack_in   = ack_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      tx_in    = tx_ff;
      done     = 1'b0;
      pins     = {scl_ff, sda_ff};
      if (pop) begin
         if (busy_ff) begin
            if (tick_inc >= limit) begin
               tick_in = '0;
               if (mode_ff == i2cmbe_pkg::MODE_RX_ACK && phase_ff == PW'(1)) begin
                  ack_in = pop_data.sda_in;
               end else if (mode_ff == i2cmbe_pkg::MODE_READ && phase_ff[0]) begin
                  if (pop_data.sda_in) begin
                     shift_in[3'd7 - phase_ff[3:1]] = 1'b1;
                  end
               end
               if (phase_inc >= phase_count(mode_ff)) begin
                  busy_in  = 1'b0;
                  phase_in = '0;
                  done     = 1'b1;
               end else begin
                  phase_in = phase_inc;
                  pins     = apply_phase(mode_ff, phase_inc, tx_ff, scl_ff, sda_ff);
                  scl_in   = pins[1];
                  sda_in   = pins[0];
               end
            end else begin
               tick_in = tick_inc;
            end
         end else if (pop_data.start) begin
            mode_in  = pop_data.mode;
            busy_in  = 1'b1;
            phase_in = '0;
            tick_in  = '0;
            tx_in    = pop_data.tx_byte;
            if (pop_data.mode == i2cmbe_pkg::MODE_READ) begin
               shift_in = '0;
            end
            pins   = apply_phase(pop_data.mode, PW'(0), pop_data.tx_byte, scl_ff, sda_ff);
            scl_in = pins[1];
            sda_in = pins[0];
         end
      end
      rsp_in.scl_out   = scl_in;
      rsp_in.sda_out   = sda_in;
      rsp_in.busy_res  = busy_in;
      rsp_in.done_res  = done;
      rsp_in.read_byte = shift_in;
      rsp_in.ack_seen  = ack_in;
      rsp_valid_in     = pop | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= i2cmbe_pkg::MODE_START;
         busy_ff      <= 1'b0;
         phase_ff     <= '0;
         tick_ff      <= '0;
         shift_ff     <= '0;
         ack_ff       <= 1'b1;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         tx_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         shift_ff     <= shift_in;
         ack_ff       <= ack_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         tx_ff        <= tx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: src/i2c_master_bit_engine.sv
// i2c master bit engine top level: front end, queue, back end and csr
// a tick word is registered in the queue entry and then in the back end result register
// before its earliest result handshake
// throughput: one tick word per clock while the result side takes each result word
// the two-entry queue and the result register let each side stall on its own
// reset: idle, both pins released, ack seen 1, read byte 0, ticks per phase 1
`default_nettype none

module i2c_master_bit_engine (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  i2cmbe_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output i2cmbe_pkg::rsp_type                 rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [i2cmbe_pkg::TickWidth-1:0]    csr_data
);

   logic [i2cmbe_pkg::TickWidth-1:0] tpp_ff;
   logic                             push_valid, push_ready;
   i2cmbe_pkg::tick_type             push_data;
   logic                             pop_valid, pop_ready;
   i2cmbe_pkg::tick_type             pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpp_ff <= i2cmbe_pkg::TickWidth'(1);
      end else if (csr_valid) begin
         tpp_ff <= csr_data;
      end
   end

   i2cmbe_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   i2cmbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   i2cmbe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .ticks_per_phase (tpp_ff),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

endmodule

`default_nettype wire

// File: sim/i2cmbe_checker.sv
// checker for the i2c master bit engine: predicts each tick's result word and compares
`timescale 1ns / 100ps

module i2cmbe_checker
   import i2cmbe_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_ready,
   input  req_type               req_data,
   input  wire                   rsp_valid,
   input  wire                   rsp_ready,
   input  rsp_type               rsp_data,
   input  wire                   csr_valid,
   input  wire                   csr_ready,
   input  wire [TickWidth-1:0]   csr_data,
   output int                    fail_count,
   output int                    pending
);

   logic [TickWidth-1:0]  tpp_reg;
   logic [2:0]            eng_mode;
   logic                  eng_busy;
   logic [PhaseWidth-1:0] eng_phase;
   logic [TickWidth-1:0]  eng_ticks;
   logic [7:0]            eng_shift;
   logic                  eng_ack;
   logic                  eng_scl;
   logic                  eng_sda;
   logic [7:0]            eng_tx;

   rsp_type bus_level_q[$];
   int      fails;

   initial begin
      fails = 0;
   end

   function automatic int phase_total(input logic [2:0] m);
      case (m)
         MODE_START:  return 4;
         MODE_WRITE:  return 24;
         MODE_RX_ACK: return 3;
         MODE_READ:   return 17;
         default:     return 3;
      endcase
   endfunction

   task automatic drive_phase_levels();
      int p;
      int bit_pos;
      p = int'(eng_phase);
      case (eng_mode)
         MODE_START: begin
            if (p == 0) eng_sda = 1'b1;
            else if (p == 1) eng_scl = 1'b1;
            else if (p == 2) eng_sda = 1'b0;
            else eng_scl = 1'b0;
         end
         MODE_WRITE: begin
            bit_pos = (p / 3) % 8;
            if (p % 3 == 0) eng_sda = eng_tx[7 - bit_pos];
            else if (p % 3 == 1) eng_scl = 1'b1;
            else eng_scl = 1'b0;
         end
         MODE_READ: begin
            if (p == 0) eng_sda = 1'b1;
            else eng_scl = ((p - 1) % 2 == 0);
         end
         MODE_RX_ACK, MODE_TX_ACK: begin
            if (p == 0) eng_sda = (eng_mode == MODE_RX_ACK) ? 1'b1 : eng_tx[0];
            else if (p == 1) eng_scl = 1'b1;
            else eng_scl = 1'b0;
         end
         default: begin
            if (p == 0) eng_sda = 1'b0;
            else if (p == 1) eng_scl = 1'b1;
            else eng_sda = 1'b1;
         end
      endcase
   endtask

   task automatic advance_engine(input req_type w, output rsp_type r);
      int unsigned lim;
      int          p;
      logic        done;
      lim  = (tpp_reg == '0) ? 1 : int'(tpp_reg);
      done = 1'b0;
      if (eng_busy) begin
         eng_ticks = eng_ticks + 1'b1;
         if (eng_ticks >= lim) begin
            eng_ticks = '0;
            p = int'(eng_phase);
            if (eng_mode == MODE_RX_ACK && p == 1) begin
               eng_ack = w.sda_in;
            end else if (eng_mode == MODE_READ && p >= 1 && (p - 1) % 2 == 0) begin
               if (w.sda_in) eng_shift[7 - (((p - 1) / 2) % 8)] = 1'b1;
            end
            eng_phase = eng_phase + 1'b1;
            if (eng_phase >= phase_total(eng_mode)) begin
               eng_busy  = 1'b0;
               eng_phase = '0;
               done      = 1'b1;
            end else begin
               drive_phase_levels();
            end
         end
      end else if (w.cmd_valid && w.mode <= MODE_STOP) begin
         eng_mode  = w.mode;
         eng_busy  = 1'b1;
         eng_phase = '0;
         eng_ticks = '0;
         eng_tx    = (w.mode == MODE_TX_ACK) ? {7'd0, w.ack_bit} : w.data_byte;
         if (w.mode == MODE_READ) eng_shift = '0;
         drive_phase_levels();
      end
      r.scl_out   = eng_scl;
      r.sda_out   = eng_sda;
      r.busy_res  = eng_busy;
      r.done_res  = done;
      r.read_byte = eng_shift;
      r.ack_seen  = eng_ack;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      logic    differs;
      if (reset) begin
         tpp_reg   = 16'd1;
         eng_mode  = MODE_START;
         eng_busy  = 1'b0;
         eng_phase = '0;
         eng_ticks = '0;
         eng_shift = '0;
         eng_ack   = 1'b1;
         eng_scl   = 1'b1;
         eng_sda   = 1'b1;
         eng_tx    = '0;
         bus_level_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (bus_level_q.size() == 0) begin
               if (fails < 10)
                  $display("unexpected result word: scl %b sda %b busy %b done %b byte %h ack %b",
                           got.scl_out, got.sda_out, got.busy_res, got.done_res,
                           got.read_byte, got.ack_seen);
               fails++;
            end else begin
               want    = bus_level_q.pop_front();
               differs = 1'b0;
               if (got.scl_out   !== want.scl_out)   differs = 1'b1;
               if (got.sda_out   !== want.sda_out)   differs = 1'b1;
               if (got.busy_res  !== want.busy_res)  differs = 1'b1;
               if (got.done_res  !== want.done_res)  differs = 1'b1;
               if (got.read_byte !== want.read_byte) differs = 1'b1;
               if (got.ack_seen  !== want.ack_seen)  differs = 1'b1;
               if (differs) begin
                  if (fails < 10)
                     $display({"mismatch at %0t: expected scl %b sda %b busy %b done %b",
                               " byte %h ack %b, got scl %b sda %b busy %b done %b",
                               " byte %h ack %b"}, $realtime,
                              want.scl_out, want.sda_out, want.busy_res, want.done_res,
                              want.read_byte, want.ack_seen,
                              got.scl_out, got.sda_out, got.busy_res, got.done_res,
                              got.read_byte, got.ack_seen);
                  fails++;
               end
            end
         end
         if (csr_valid && csr_ready) tpp_reg = csr_data;
         if (req_valid && req_ready) begin
            advance_engine(req_data, want);
            bus_level_q.push_back(want);
         end
      end
      fail_count <= fails;
      pending    <= bus_level_q.size();
   end

endmodule

// File: sim/tb_i2c_master_bit_engine.sv
// testbench top for the i2c master bit engine: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine;
   import i2cmbe_pkg::*;

   localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
   localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [TickWidth-1:0] csr_data  = '0;

   int                   fail_count;
   int                   pending;
   int                   send_gap_pct   = 27;
   int                   recv_stall_pct = 62;
   int                   sda_hold       = -1;
   int                   ticks_sent     = 0;
   logic [TickWidth-1:0] cur_tpp        = 16'd1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   i2c_master_bit_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   i2cmbe_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic int command_phases(input logic [2:0] m);
      case (m)
         MODE_START:  return 4;
         MODE_WRITE:  return 24;
         MODE_RX_ACK: return 3;
         MODE_READ:   return 17;
         MODE_TX_ACK: return 3;
         MODE_STOP:   return 3;
         default:     return 0;
      endcase
   endfunction

   function automatic int full_pad(input logic [2:0] m);
      return command_phases(m) * ((cur_tpp == '0) ? 1 : int'(cur_tpp));
   endfunction

   function automatic req_type random_word(input logic valid);
      req_type w;
      w.cmd_valid = valid;
      w.mode      = 3'($urandom_range(7));
      w.data_byte = 8'($urandom_range(255));
      w.ack_bit   = 1'($urandom_range(1));
      w.sda_in    = (sda_hold < 0) ? 1'($urandom_range(1)) : 1'(sda_hold);
      return w;
   endfunction

   // called at a clock edge; leaves the word on the bus until it is taken
   task automatic send_tick(input req_type w);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic send_idle(input int n);
      repeat (n) send_tick(random_word(1'b0));
   endtask

   // command word, then filler words that land while the engine is busy
   task automatic issue_command(input logic [2:0] m, input logic [7:0] byte_val,
                                input logic ack_val, input int pad);
      req_type w;
      w           = random_word(1'b1);
      w.mode      = m;
      w.data_byte = byte_val;
      w.ack_bit   = ack_val;
      send_tick(w);
      for (int i = 0; i < pad; i++) send_tick(random_word($urandom_range(3) == 0));
   endtask

   task automatic run_transfer();
      int n;
      n = $urandom_range(3, 1);
      issue_command(MODE_START, 8'($urandom_range(255)), 1'b0, full_pad(MODE_START));
      issue_command(MODE_WRITE, 8'($urandom_range(255)), 1'b0, full_pad(MODE_WRITE));
      issue_command(MODE_RX_ACK, 8'($urandom_range(255)), 1'b0, full_pad(MODE_RX_ACK));
      if ($urandom_range(1)) begin
         repeat (n) begin
            issue_command(MODE_WRITE, 8'($urandom_range(255)), 1'b0, full_pad(MODE_WRITE));
            issue_command(MODE_RX_ACK, 8'($urandom_range(255)), 1'b0, full_pad(MODE_RX_ACK));
         end
      end else begin
         repeat (n) begin
            issue_command(MODE_READ, 8'($urandom_range(255)), 1'b0, full_pad(MODE_READ));
            issue_command(MODE_TX_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          full_pad(MODE_TX_ACK));
         end
      end
      issue_command(MODE_STOP, 8'($urandom_range(255)), 1'b0, full_pad(MODE_STOP));
   endtask

   task automatic run_random(input int count);
      int      target;
      logic [2:0] m;
      target = ticks_sent + count;
      while (ticks_sent < target) begin
         if ($urandom_range(9) < 7) begin
            run_transfer();
         end else begin
            m = 3'($urandom_range(7));
            issue_command(m, 8'($urandom_range(255)), 1'($urandom_range(1)),
                          full_pad(m) + int'($urandom_range(6)) - 3);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_tpp(input logic [TickWidth-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_tpp = v;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_tpp(16'd1);

      // directed: every command, byte extremes, both ack levels
      issue_command(MODE_START, 8'h00, 1'b0, full_pad(MODE_START));
      issue_command(MODE_WRITE, 8'h00, 1'b0, full_pad(MODE_WRITE));
      sda_hold = 0;
      issue_command(MODE_RX_ACK, 8'h00, 1'b0, full_pad(MODE_RX_ACK));
      sda_hold = -1;
      issue_command(MODE_WRITE, 8'hFF, 1'b1, full_pad(MODE_WRITE));
      sda_hold = 1;
      issue_command(MODE_RX_ACK, 8'hFF, 1'b1, full_pad(MODE_RX_ACK));
      issue_command(MODE_READ, 8'h00, 1'b0, full_pad(MODE_READ));
      issue_command(MODE_TX_ACK, 8'h00, 1'b0, full_pad(MODE_TX_ACK));
      sda_hold = 0;
      issue_command(MODE_READ, 8'hFF, 1'b1, full_pad(MODE_READ));
      issue_command(MODE_TX_ACK, 8'hFF, 1'b1, full_pad(MODE_TX_ACK));
      sda_hold = -1;
      issue_command(MODE_READ, 8'h5A, 1'b0, full_pad(MODE_READ));
      issue_command(MODE_WRITE, 8'hA5, 1'b0, full_pad(MODE_WRITE));
      issue_command(MODE_STOP, 8'h00, 1'b0, full_pad(MODE_STOP));
      // command while busy, command on the done word, undefined modes
      issue_command(MODE_WRITE, 8'h3C, 1'b0, full_pad(MODE_WRITE) - 10);
      issue_command(MODE_START, 8'h00, 1'b0, 0);
      send_idle(12);
      issue_command(MODE_STOP, 8'h00, 1'b0, full_pad(MODE_STOP) - 1);
      issue_command(MODE_READ, 8'h00, 1'b0, 0);
      send_idle(2);
      issue_command(MODE_UNDEF_LO, 8'hFF, 1'b1, 2);
      issue_command(MODE_UNDEF_HI, 8'hFF, 1'b1, 2);
      wait_drained();

      // longest phase, then zero (behaves as one) part way through a phase
      write_tpp(16'hFFFF);
      issue_command(MODE_START, 8'h00, 1'b0, 8);
      wait_drained();
      write_tpp(16'd0);
      send_idle(8);
      run_random(200);
      wait_drained();

      write_tpp(16'd3);
      send_gap_pct   = 62;
      recv_stall_pct = 27;
      run_random(200);
      wait_drained();

      write_tpp(16'($urandom_range(4, 1)));
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      run_random(200);
      wait_drained();

      repeat (16) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
src/i2cmbe_pkg.sv
src/i2cmbe_front.sv
src/i2cmbe_queue.sv
src/i2cmbe_back.sv
src/i2c_master_bit_engine.sv
sim/i2cmbe_checker.sv
sim/tb_i2c_master_bit_engine.sv
